>>> hw/rtl/lrc_pkg.sv
package lrc_pkg;

  localparam int IMAGE_DIM  = 256;
  localparam int NUM_LABELS = 64;

  localparam int POS_W   = 8;
  localparam int LABEL_W = 6;
  localparam int COUNT_W = 7;
  localparam int SUM_W   = 24;
  localparam int TALLY_W = 17;
  localparam int ADDR_W  = $clog2(NUM_LABELS);
  localparam int STEP_W  = $clog2(SUM_W);

  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};
  localparam logic [POS_W-1:0]   MEAN_MAX  = {POS_W{1'b1}};

  typedef struct packed {
    logic [SUM_W-1:0]   row_sum;
    logic [SUM_W-1:0]   col_sum;
    logic [TALLY_W-1:0] tally;
  } acc_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_SCAN_RD,
    S_LOAD,
    S_DIV_ROW,
    S_DIV_COL,
    S_EMIT
  } state_t;

endpackage

>>> hw/rtl/lrc_ifs.sv
interface lrc_pixel_if;
  import lrc_pkg::*;
  logic               valid;
  logic               ready;
  logic [POS_W-1:0]   pixel_row;
  logic [POS_W-1:0]   pixel_col;
  logic [LABEL_W-1:0] label;
  logic               last_pixel;
  modport source (output valid, pixel_row, pixel_col, label, last_pixel, input ready);
  modport sink   (input valid, pixel_row, pixel_col, label, last_pixel, output ready);
endinterface

interface lrc_centroid_if;
  import lrc_pkg::*;
  logic               valid;
  logic               ready;
  logic [LABEL_W-1:0] region_label;
  logic [POS_W-1:0]   centroid_row;
  logic [POS_W-1:0]   centroid_col;
  logic               last_region;
  modport source (output valid, region_label, centroid_row, centroid_col, last_region,
                  input ready);
  modport sink   (input valid, region_label, centroid_row, centroid_col, last_region,
                  output ready);
endinterface

interface lrc_cfg_if;
  import lrc_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> hw/rtl/label_region_centroids_core.sv
// Pixel word: accepted in idle, where the label accumulators are read, and written back
//   in the update state, so a new pixel word is taken only once that update is done.
// Last pixel: each emitted label, 1 to limit - 1, runs read, load, 24 + 24 steps of the
//   shared restoring divider and emit; emit waits while the output word is not taken.
// Reset (rst, synchronous): all per-label valid bits clear at once, label_count = 1,
//   no clearing pass; the accumulator memory is not reset; both ready lines low in reset.
module label_region_centroids_core (
  input  logic           clk,
  input  logic           rst,
  lrc_cfg_if.sink        cfg,
  lrc_pixel_if.sink      pixels,
  lrc_centroid_if.source centroids
);
  import lrc_pkg::*;

  state_t state, state_next;

  // Configuration register
  logic [COUNT_W-1:0] label_count;
  logic [COUNT_W-1:0] limit;

  // Captured pixel word
  logic [POS_W-1:0]   pix_row;
  logic [POS_W-1:0]   pix_col;
  logic [ADDR_W-1:0]  pix_label;
  logic               pix_last;
  logic               pix_ok;

  // Accumulator memory and per-entry valid bits
  acc_t               mem [NUM_LABELS];
  acc_t               rd_word;
  logic               rd_hit;
  logic [ADDR_W-1:0]  rd_addr;
  logic [NUM_LABELS-1:0] valid;
  acc_t               acc_cur;
  acc_t               wr_word;

  // Saturating adders
  logic [SUM_W:0]     row_add;
  logic [SUM_W:0]     col_add;
  logic [TALLY_W:0]   tally_add;

  // Shared divider
  logic [SUM_W-1:0]   dvd;
  logic [TALLY_W-1:0] dvs;
  logic [TALLY_W-1:0] rem;
  logic [STEP_W-1:0]  step;
  logic               div_zero;
  logic [SUM_W-1:0]   col_hold;
  logic [TALLY_W:0]   rem_sh;
  logic               ge;
  logic [TALLY_W:0]   rem_nx;
  logic [SUM_W-1:0]   dvd_nx;
  logic [POS_W-1:0]   q_clamp;
  logic               step_last;
  logic [POS_W-1:0]   row_q;

  // Label walk and output register
  logic [ADDR_W-1:0]  scan_label;
  logic               scan_final;
  logic               out_valid;
  logic [LABEL_W-1:0] out_label;
  logic [POS_W-1:0]   out_row;
  logic [POS_W-1:0]   out_col;
  logic               out_last;

  // Control decoded from the state
  logic               take_pixel;
  logic               mem_we;
  logic               clear_all;
  logic               emit_go;
  logic               pixel_good;

  // Hold off config words while in reset
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      label_count <= COUNT_W'(1);
    end else if (cfg.valid && cfg.ready) begin
      label_count <= cfg.data;
    end
  end

  // Labels above the store depth act as the store depth
  assign limit = (label_count > COUNT_W'(NUM_LABELS)) ? COUNT_W'(NUM_LABELS) : label_count;
  assign scan_final = ({1'b0, scan_label} + COUNT_W'(1)) == limit;

  // Drop background, out-of-range labels and out-of-image positions
  assign pixel_good = (pixels.label != '0) && (int'(pixels.label) < NUM_LABELS) &&
                      (int'(pixels.pixel_row) < IMAGE_DIM) &&
                      (int'(pixels.pixel_col) < IMAGE_DIM);

  always_ff @(posedge clk) begin
    if (take_pixel) begin
      pix_row   <= pixels.pixel_row;
      pix_col   <= pixels.pixel_col;
      pix_label <= ADDR_W'(pixels.label);
      pix_last  <= pixels.last_pixel;
      pix_ok    <= pixel_good;
    end
  end

  // Read port follows the incoming label in idle and the walk otherwise
  assign rd_addr = (state == S_IDLE) ? ADDR_W'(pixels.label) : scan_label;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pix_label] <= wr_word;
    end
    rd_word <= mem[rd_addr];
    rd_hit  <= valid[rd_addr];
  end

  // An entry never written since the last clear reads as zero
  assign acc_cur = rd_hit ? rd_word : '0;

  assign row_add   = {1'b0, acc_cur.row_sum} + (SUM_W+1)'(pix_row);
  assign col_add   = {1'b0, acc_cur.col_sum} + (SUM_W+1)'(pix_col);
  assign tally_add = {1'b0, acc_cur.tally} + (TALLY_W+1)'(1);

  always_comb begin
    wr_word.row_sum = row_add[SUM_W] ? SUM_MAX : row_add[SUM_W-1:0];
    wr_word.col_sum = col_add[SUM_W] ? SUM_MAX : col_add[SUM_W-1:0];
    wr_word.tally   = tally_add[TALLY_W] ? TALLY_MAX : tally_add[TALLY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (mem_we) begin
        valid[pix_label] <= 1'b1;
      end
      if (clear_all) begin
        valid <= '0;
      end
    end
  end

  // Restoring division, one quotient bit per cycle
  assign rem_sh    = {rem, dvd[SUM_W-1]};
  assign ge        = rem_sh >= {1'b0, dvs};
  assign rem_nx    = ge ? (rem_sh - {1'b0, dvs}) : rem_sh;
  assign dvd_nx    = {dvd[SUM_W-2:0], ge};
  assign step_last = step == STEP_W'(SUM_W - 1);

  // Empty label gives zero; a mean above the pixel range clamps
  assign q_clamp = div_zero ? '0 :
                   (dvd_nx[SUM_W-1:POS_W] != '0) ? MEAN_MAX : dvd_nx[POS_W-1:0];

  always_ff @(posedge clk) begin
    unique case (state)
      S_LOAD: begin
        dvd      <= acc_cur.row_sum;
        dvs      <= acc_cur.tally;
        col_hold <= acc_cur.col_sum;
        div_zero <= acc_cur.tally == '0;
        rem      <= '0;
        step     <= '0;
      end
      S_DIV_ROW: begin
        if (step_last) begin
          row_q <= q_clamp;
          dvd   <= col_hold;
          rem   <= '0;
          step  <= '0;
        end else begin
          dvd  <= dvd_nx;
          rem  <= rem_nx[TALLY_W-1:0];
          step <= step + STEP_W'(1);
        end
      end
      S_DIV_COL: begin
        dvd  <= dvd_nx;
        rem  <= rem_nx[TALLY_W-1:0];
        step <= step + STEP_W'(1);
        if (step_last) begin
          out_col <= q_clamp;
        end
      end
      default: begin
      end
    endcase
  end

  // Walk the labels from 1 upward
  always_ff @(posedge clk) begin
    if (state == S_UPDATE) begin
      scan_label <= ADDR_W'(1);
    end else if (emit_go) begin
      scan_label <= scan_label + ADDR_W'(1);
    end
  end

  // Output register: hold the word until taken, idle can run meanwhile
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (centroids.ready) begin
      out_valid <= 1'b0;
    end
  end

  logic [POS_W-1:0] col_res;

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_label <= LABEL_W'(scan_label);
      out_row   <= row_q;
      col_res   <= out_col;
      out_last  <= scan_final;
    end
  end

  assign centroids.valid        = out_valid;
  assign centroids.region_label = out_label;
  assign centroids.centroid_row = out_row;
  assign centroids.centroid_col = col_res;
  assign centroids.last_region  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (pixels.valid) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (pix_last && (limit > COUNT_W'(1))) begin
          state_next = S_SCAN_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SCAN_RD: state_next = S_LOAD;
      S_LOAD:    state_next = S_DIV_ROW;
      S_DIV_ROW: begin
        if (step_last) begin
          state_next = S_DIV_COL;
        end
      end
      S_DIV_COL: begin
        if (step_last) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid || centroids.ready) begin
          state_next = scan_final ? S_IDLE : S_SCAN_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Decoded controls
  always_comb begin
    pixels.ready = 1'b0;
    take_pixel   = 1'b0;
    mem_we       = 1'b0;
    clear_all    = 1'b0;
    emit_go      = 1'b0;
    unique case (state)
      S_IDLE: begin
        pixels.ready = !rst;
        take_pixel   = pixels.valid;
      end
      S_UPDATE: begin
        mem_we    = pix_ok;
        clear_all = pix_last && (limit <= COUNT_W'(1));
      end
      S_EMIT: begin
        emit_go   = !out_valid || centroids.ready;
        clear_all = emit_go && scan_final;
      end
      default: begin
      end
    endcase
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    pixels.ready |-> (state == S_IDLE))
    else $error("pixel ready outside idle");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DIV_ROW) || (state == S_DIV_COL)) |-> (step < STEP_W'(SUM_W)))
    else $error("divider step past the dividend width");

  a_emit_label_range: assert property (@(posedge clk) disable iff (rst)
    emit_go |-> ((scan_label != '0) && ({1'b0, scan_label} < limit)))
    else $error("emitted label outside the configured range");

  a_clear_after_image: assert property (@(posedge clk) disable iff (rst)
    clear_all |=> (valid == '0))
    else $error("stores not cleared after the image");

  a_reset_state: assert property (@(posedge clk)
    rst |=> ((state == S_IDLE) && !out_valid && (valid == '0)))
    else $error("reset did not return to idle");

endmodule

>>> test/tb_label_region_centroids_core.sv
module tb_label_region_centroids_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lrc_pkg::*;

  // Worst case is every pixel word closing an image of 63 labels;
  // take that several times over.
  localparam int CYCLE_LIMIT   = 10_000_000;
  // Cycles to hold after the last centroid word before touching the config.
  localparam int SETTLE_CYCLES = 64;
  // Pixels of one label sent back to back through the read-modify-write path.
  localparam int RUN_PIXELS    = 40;
  localparam int RANDOM_ITEMS  = 340;

  typedef struct packed {
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [LABEL_W-1:0] label;
    logic               last;
  } pixel_t;

  typedef struct packed {
    logic [LABEL_W-1:0] region;
    logic [POS_W-1:0]   crow;
    logic [POS_W-1:0]   ccol;
    logic               last;
  } centroid_t;

  logic clk;
  logic rst;

  lrc_cfg_if      cfg_ch ();
  lrc_pixel_if    pix_ch ();
  lrc_centroid_if cen_ch ();

  label_region_centroids_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_ch),
    .pixels    (pix_ch),
    .centroids (cen_ch)
  );

  // Shadow copy of the block: per-label accumulators and the label_count register.
  logic [SUM_W-1:0]   row_acc   [NUM_LABELS];
  logic [SUM_W-1:0]   col_acc   [NUM_LABELS];
  logic [TALLY_W-1:0] tally_acc [NUM_LABELS];
  logic [COUNT_W-1:0] count_reg;

  centroid_t pending_centroids[$];

  int send_idle_pct;
  int stall_pct;
  int cycle_count;
  int mismatch_count;
  int pixel_words;
  int centroid_words;
  int image_count;
  int count_writes;

  centroid_t got_word;
  centroid_t want_word;

  // Clock: 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] a, logic [POS_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W+1)'(b);
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] mean_of(logic [SUM_W-1:0] s, logic [TALLY_W-1:0] n);
    logic [SUM_W-1:0] q;
    if (n == '0) begin
      return '0;
    end
    q = s / SUM_W'(n);
    return (q > SUM_W'(MEAN_MAX)) ? MEAN_MAX : q[POS_W-1:0];
  endfunction

  function automatic void clear_accumulators();
    for (int i = 0; i < NUM_LABELS; i++) begin
      row_acc[i]   = '0;
      col_acc[i]   = '0;
      tally_acc[i] = '0;
    end
  endfunction

  // Fold one accepted pixel word into the shadow stores; on the last pixel
  // queue one centroid word per emitted label and start the next image clean.
  function automatic void absorb_pixel(pixel_t p);
    int        top;
    centroid_t c;
    if (p.label != '0 && p.label < NUM_LABELS && p.row < IMAGE_DIM && p.col < IMAGE_DIM) begin
      row_acc[p.label] = sat_sum(row_acc[p.label], p.row);
      col_acc[p.label] = sat_sum(col_acc[p.label], p.col);
      if (tally_acc[p.label] != TALLY_MAX) begin
        tally_acc[p.label] = tally_acc[p.label] + TALLY_W'(1);
      end
    end
    if (!p.last) begin
      return;
    end
    // A count above the store depth acts as the full depth.
    top = (count_reg > NUM_LABELS) ? NUM_LABELS : int'(count_reg);
    for (int k = 1; k < top; k++) begin
      c.region = k[LABEL_W-1:0];
      c.crow   = mean_of(row_acc[k], tally_acc[k]);
      c.ccol   = mean_of(col_acc[k], tally_acc[k]);
      c.last   = (k + 1 == top);
      pending_centroids.push_back(c);
    end
    clear_accumulators();
    image_count++;
  endfunction

  function automatic void note_mismatch(string what, centroid_t want, centroid_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0d] %s: expected label %0d row %0d col %0d last %0b,",
               cycle_count, what, want.region, want.crow, want.ccol, want.last);
      $display("      got label %0d row %0d col %0d last %0b",
               got.region, got.crow, got.ccol, got.last);
    end
  endfunction

  // Drive one pixel word, with random idle cycles ahead of it, and hold it
  // until the block takes it. Valid stays high after acceptance so that a
  // back-to-back word needs only one assignment in that step.
  task automatic send_pixel(pixel_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid      <= 1'b1;
    pix_ch.pixel_row  <= p.row;
    pix_ch.pixel_col  <= p.col;
    pix_ch.label      <= p.label;
    pix_ch.last_pixel <= p.last;
    @(posedge clk);
    while (!pix_ch.ready) begin
      @(posedge clk);
    end
    pixel_words++;
    absorb_pixel(p);
  endtask

  // Drop valid, wait for every expected centroid word, then hold a while so
  // the block is back in idle before the next config word.
  task automatic settle_idle();
    pix_ch.valid <= 1'b0;
    while (pending_centroids.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_label_count(logic [COUNT_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) begin
      @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
    count_reg = value;
    count_writes++;
    @(posedge clk);
  endtask

  function automatic pixel_t make_pixel(int r, int c, int lab, bit last);
    pixel_t p;
    p.row   = r[POS_W-1:0];
    p.col   = c[POS_W-1:0];
    p.label = lab[LABEL_W-1:0];
    p.last  = last;
    return p;
  endfunction

  // Out of reset label_count is 1, so an image ends with no centroid words.
  task automatic test_reset_count();
    send_pixel(make_pixel(5, 7, 1, 1'b0));
    send_pixel(make_pixel(9, 3, 2, 1'b1));
    settle_idle();
  endtask

  // Corners of the position range, top label, background pixels and empty labels.
  task automatic test_extremes();
    write_label_count(7'd64);
    send_pixel(make_pixel(0, 0, 1, 1'b0));
    send_pixel(make_pixel(255, 255, 1, 1'b0));
    send_pixel(make_pixel(255, 0, 63, 1'b0));
    send_pixel(make_pixel(0, 255, 63, 1'b0));
    send_pixel(make_pixel(255, 255, 63, 1'b0));
    send_pixel(make_pixel(255, 255, 0, 1'b0));
    send_pixel(make_pixel(128, 64, 32, 1'b0));
    // Last pixel on background: it still closes the image.
    send_pixel(make_pixel(255, 255, 0, 1'b1));
    settle_idle();
    // Last pixel that carries a label is counted before the output.
    send_pixel(make_pixel(3, 4, 2, 1'b0));
    send_pixel(make_pixel(200, 100, 2, 1'b1));
    settle_idle();
  endtask

  // Stores clear after each image, also when nothing was emitted; counts above
  // the store depth clip to it.
  task automatic test_count_edges();
    write_label_count(7'd127);
    send_pixel(make_pixel(10, 20, 5, 1'b0));
    send_pixel(make_pixel(30, 40, 63, 1'b1));
    settle_idle();
    write_label_count(7'd0);
    send_pixel(make_pixel(100, 100, 1, 1'b0));
    send_pixel(make_pixel(50, 60, 1, 1'b1));
    settle_idle();
    write_label_count(7'd2);
    send_pixel(make_pixel(1, 2, 1, 1'b1));
    settle_idle();
    write_label_count(7'd65);
    send_pixel(make_pixel(77, 88, 1, 1'b0));
    send_pixel(make_pixel(11, 22, 60, 1'b1));
    settle_idle();
    write_label_count(7'd1);
    send_pixel(make_pixel(255, 255, 1, 1'b1));
    settle_idle();
  endtask

  // Hammer label 1 with back-to-back pixels so each update reads the word
  // written just before it.
  task automatic test_label_run();
    write_label_count(7'd3);
    send_pixel(make_pixel(10, 20, 2, 1'b0));
    for (int i = 0; i < RUN_PIXELS; i++) begin
      send_pixel(make_pixel(255 - i, 3 * i, 1, 1'b0));
    end
    send_pixel(make_pixel(255, 255, 1, 1'b1));
    settle_idle();
  endtask

  // Random images: a fresh count most of the time, labels mostly in the
  // emitted range, some background and some above the count.
  task automatic run_random_images(int budget);
    int     sent;
    int     len;
    int     top;
    int     pick;
    pixel_t p;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(9))
          0:       top = $urandom_range(1);
          1:       top = $urandom_range(65, 127);
          2:       top = NUM_LABELS;
          3:       top = $urandom_range(2, 63);
          default: top = $urandom_range(2, 12);
        endcase
        write_label_count(top[COUNT_W-1:0]);
      end
      top = (count_reg > NUM_LABELS) ? NUM_LABELS : int'(count_reg);
      len = $urandom_range(1, 30);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(99);
        p.row  = POS_W'($urandom);
        p.col  = POS_W'($urandom);
        if (pick < 15 || top < 2) begin
          p.label = LABEL_W'($urandom);
        end else if (pick < 30) begin
          p.label = '0;
        end else begin
          p.label = LABEL_W'($urandom_range(1, top - 1));
        end
        p.last = (i == len - 1);
        send_pixel(p);
      end
      sent += len;
      settle_idle();
    end
  endtask

  task automatic test_random_phases();
    send_idle_pct = 0;  stall_pct = 0;
    run_random_images(RANDOM_ITEMS / 4);
    send_idle_pct = 61; stall_pct = 0;
    run_random_images(RANDOM_ITEMS / 4);
    send_idle_pct = 0;  stall_pct = 61;
    run_random_images(RANDOM_ITEMS / 4);
    send_idle_pct = 27; stall_pct = 27;
    run_random_images(RANDOM_ITEMS / 4);
  endtask

  // Receiver: stall at the current rate, one draw per cycle.
  always @(posedge clk) begin
    cen_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each accepted centroid word with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && cen_ch.valid && cen_ch.ready) begin
      got_word.region = cen_ch.region_label;
      got_word.crow   = cen_ch.centroid_row;
      got_word.ccol   = cen_ch.centroid_col;
      got_word.last   = cen_ch.last_region;
      centroid_words++;
      if (pending_centroids.size() == 0) begin
        note_mismatch("centroid word with none expected", '0, got_word);
      end else begin
        want_word = pending_centroids.pop_front();
        if (got_word.region !== want_word.region || got_word.crow !== want_word.crow ||
            got_word.ccol !== want_word.ccol || got_word.last !== want_word.last) begin
          note_mismatch("centroid mismatch", want_word, got_word);
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d centroid words still expected",
               cycle_count, pending_centroids.size());
      $display("tb_label_region_centroids_core NOT OK");
      $finish;
    end
  end

  initial begin
    // Known values on reset and every config and pixel input from time zero.
    rst               = 1'b1;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = '0;
    pix_ch.valid      = 1'b0;
    pix_ch.pixel_row  = '0;
    pix_ch.pixel_col  = '0;
    pix_ch.label      = '0;
    pix_ch.last_pixel = 1'b0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    mismatch_count    = 0;
    pixel_words       = 0;
    centroid_words    = 0;
    image_count       = 0;
    count_writes      = 0;
    count_reg         = 7'd1;
    clear_accumulators();

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_count();
    test_extremes();
    test_count_edges();
    test_label_run();
    test_random_phases();

    settle_idle();
    if (pending_centroids.size() != 0) begin
      mismatch_count++;
    end
    $display("%0d pixel words in %0d images, %0d centroid words checked, %0d mismatches",
             pixel_words, image_count, centroid_words, mismatch_count);
    $display("%0d label_count writes from 0 to 127, a same-label run, four idling mixes",
             count_writes);
    if (mismatch_count == 0) begin
      $display("tb_label_region_centroids_core OK");
    end else begin
      $display("tb_label_region_centroids_core NOT OK");
    end
    $finish;
  end

endmodule

>>> label_region_centroids_core.f
hw/rtl/lrc_pkg.sv
hw/rtl/lrc_ifs.sv
hw/rtl/label_region_centroids_core.sv
test/tb_label_region_centroids_core.sv
